@@ hw/rtl/vns_pkg.sv @@
package vns_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_BLENDS  = 7;

    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_WRITE_PERM = 2'd1;
    localparam logic [1:0] OP_WRITE_VAL  = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [FRAC_BITS-1:0]  frac_t;

    typedef struct packed {
        logic   start;
        frac_t  t;
        value_t a;
        value_t b;
    } lerp_req_t;

    typedef struct packed {
        logic   done;
        value_t value;
    } lerp_rsp_t;

endpackage

@@ hw/rtl/value_noise_3d_sampler_core.sv @@
// Channel   Signals                         Direction  Moves one word of
// in        in_valid / in_ready + fields    input      sample or table write
// out       out_valid / out_ready + value   output     interpolated noise
//
// A table write returns no word.
// A sample holds the block from its intake to the next intake: the intake cycle,
// the eight corner lookups (three permutation reads and one value read per corner,
// one read per cycle on the single-port tables), the seven blends on the shared
// interpolator, and the load of the output register.
// Reset clears the core's registers but not the tables; table contents are undefined until written.
// A held output word stalls only the end of the next sample, not its intake.
module value_noise_3d_sampler_core
    import vns_pkg::*;
#(
    parameter int TABLE_SIZE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  table_index,
    input  logic [15:0] table_data,
    input  logic [7:0]  x_whole,
    input  logic [7:0]  y_whole,
    input  logic [7:0]  z_whole,
    input  logic [15:0] x_frac,
    input  logic [15:0] y_frac,
    input  logic [15:0] z_frac,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] noise_value
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_BLEND,
        S_FLUSH
    } state_t;

    state_t           state_reg;
    logic [1:0]       step_reg;
    logic [2:0]       corner_reg;
    logic [2:0]       bcnt_reg;
    logic [2:0]       wptr_reg;
    logic             wait_reg;
    logic [IDX_W-1:0] x_reg;
    logic [IDX_W-1:0] y_reg;
    logic [IDX_W-1:0] z_reg;
    frac_t            tx_reg;
    frac_t            ty_reg;
    frac_t            tz_reg;
    value_t           q_reg [NUM_CORNERS];
    logic             out_valid_reg;
    value_t           out_value_reg;

    logic             accept;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] in_z;
    logic [IDX_W-1:0] in_y;
    logic [IDX_W-1:0] in_x;
    logic [IDX_W+7:0] idx_ext;
    logic [IDX_W+7:0] x_ext;
    logic [IDX_W+7:0] y_ext;
    logic [IDX_W+7:0] z_ext;
    logic [2:0]       corner_inc;
    logic [IDX_W-1:0] xc;
    logic [IDX_W-1:0] yc;
    logic [IDX_W-1:0] zc_next;

    logic             perm_we;
    logic [IDX_W-1:0] perm_addr;
    logic [IDX_W-1:0] perm_rdata;
    logic             val_we;
    logic [IDX_W-1:0] val_addr;
    value_t           val_rdata;

    lerp_req_t        lreq;
    lerp_rsp_t        lrsp;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign idx_ext = {{IDX_W{1'b0}}, table_index};
    assign x_ext   = {{IDX_W{1'b0}}, x_whole};
    assign y_ext   = {{IDX_W{1'b0}}, y_whole};
    assign z_ext   = {{IDX_W{1'b0}}, z_whole};
    assign in_idx  = idx_ext[IDX_W-1:0];
    assign in_x    = x_ext[IDX_W-1:0];
    assign in_y    = y_ext[IDX_W-1:0];
    assign in_z    = z_ext[IDX_W-1:0];

    // Corner bit 0 selects x+1, bit 1 selects y+1, bit 2 selects z+1.
    assign corner_inc = corner_reg + 3'd1;
    assign xc      = x_reg + IDX_W'(corner_reg[0]);
    assign yc      = y_reg + IDX_W'(corner_reg[1]);
    assign zc_next = z_reg + IDX_W'(corner_inc[2]);

    assign perm_we = accept && (operation == OP_WRITE_PERM);
    assign val_we  = accept && (operation == OP_WRITE_VAL);

    always_comb
    begin
        perm_addr = in_idx;
        val_addr  = in_idx;
        if (state_reg == S_IDLE)
        begin
            if (operation == OP_SAMPLE)
            begin
                perm_addr = in_z;
            end
        end
        else
        begin
            unique case (step_reg)
                2'd1:    perm_addr = yc + perm_rdata;
                2'd2:    perm_addr = xc + perm_rdata;
                2'd3:    val_addr  = perm_rdata;
                default: perm_addr = zc_next;
            endcase
        end
    end

    always_comb
    begin
        lreq.start = (state_reg == S_BLEND) && !wait_reg;
        lreq.a     = q_reg[0];
        lreq.b     = q_reg[1];
        if (bcnt_reg < 3'd4)
        begin
            lreq.t = tx_reg;
        end
        else if (bcnt_reg < 3'd6)
        begin
            lreq.t = ty_reg;
        end
        else
        begin
            lreq.t = tz_reg;
        end
    end

    vns_tables #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_tables (
        .clk        (clk),
        .perm_we    (perm_we),
        .perm_addr  (perm_addr),
        .perm_wdata (table_data[IDX_W-1:0]),
        .perm_rdata (perm_rdata),
        .val_we     (val_we),
        .val_addr   (val_addr),
        .val_wdata  (table_data),
        .val_rdata  (val_rdata)
    );

    vns_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lreq),
        .rsp   (lrsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            corner_reg    <= 3'd0;
            bcnt_reg      <= 3'd0;
            wptr_reg      <= 3'd0;
            wait_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            tz_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                q_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_FLUSH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (operation == OP_SAMPLE))
                    begin
                        x_reg      <= in_x;
                        y_reg      <= in_y;
                        z_reg      <= in_z;
                        tx_reg     <= x_frac;
                        ty_reg     <= y_frac;
                        tz_reg     <= z_frac;
                        corner_reg <= 3'd0;
                        step_reg   <= 2'd1;
                        state_reg  <= S_LOOK;
                    end
                end

                S_LOOK:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd0)
                    begin
                        q_reg[corner_reg] <= val_rdata;
                        corner_reg        <= corner_inc;
                        if (corner_reg == 3'(NUM_CORNERS - 1))
                        begin
                            bcnt_reg  <= 3'd0;
                            wptr_reg  <= 3'(NUM_CORNERS - 2);
                            wait_reg  <= 1'b0;
                            state_reg <= S_BLEND;
                        end
                    end
                end

                S_BLEND:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (lrsp.done)
                    begin
                        wait_reg <= 1'b0;
                        if (bcnt_reg == 3'(NUM_BLENDS - 1))
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            // Pop the two head entries and append the blend.
                            for (int i = 0; i < NUM_CORNERS - 2; i++)
                            begin
                                if (3'(i) == wptr_reg)
                                begin
                                    q_reg[i] <= lrsp.value;
                                end
                                else
                                begin
                                    q_reg[i] <= q_reg[i + 2];
                                end
                            end
                            if (wptr_reg == 3'(NUM_CORNERS - 2))
                            begin
                                q_reg[NUM_CORNERS - 2] <= lrsp.value;
                            end
                            wptr_reg        <= wptr_reg - 3'd1;
                            bcnt_reg        <= bcnt_reg + 3'd1;
                        end
                    end
                end

                S_FLUSH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_value_reg <= lrsp.value;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = out_value_reg;

endmodule

@@ hw/rtl/vns_tables.sv @@
module vns_tables
    import vns_pkg::*;
#(
    parameter int TABLE_SIZE = 256,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
)
(
    input  logic             clk,
    input  logic             perm_we,
    input  logic [IDX_W-1:0] perm_addr,
    input  logic [IDX_W-1:0] perm_wdata,
    output logic [IDX_W-1:0] perm_rdata,
    input  logic             val_we,
    input  logic [IDX_W-1:0] val_addr,
    input  value_t           val_wdata,
    output value_t           val_rdata
);

    logic [IDX_W-1:0] perm_mem [TABLE_SIZE];
    value_t           val_mem  [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_addr] <= perm_wdata;
        end
        perm_rdata <= perm_mem[perm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_addr] <= val_wdata;
        end
        val_rdata <= val_mem[val_addr];
    end

endmodule

@@ hw/rtl/vns_lerp.sv @@
module vns_lerp
    import vns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lerp_req_t req,
    output lerp_rsp_t rsp
);

    localparam int DW = VALUE_BITS + 1;
    localparam int PW = DW + FRAC_BITS + 1;

    logic                 s1_valid_reg;
    value_t               s1_a_reg;
    frac_t                s1_t_reg;
    logic signed [DW-1:0] s1_diff_reg;
    logic                 s2_valid_reg;
    value_t               s2_a_reg;
    logic signed [PW-1:0] s2_prod_reg;

    logic signed [PW-1:0]     prod_shift;
    logic [VALUE_BITS:0]      sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s1_a_reg     <= '0;
            s1_t_reg     <= '0;
            s1_diff_reg  <= '0;
            s2_a_reg     <= '0;
            s2_prod_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= req.start;
            s2_valid_reg <= s1_valid_reg;
            if (req.start)
            begin
                s1_a_reg    <= req.a;
                s1_t_reg    <= req.t;
                s1_diff_reg <= $signed({1'b0, req.b}) - $signed({1'b0, req.a});
            end
            if (s1_valid_reg)
            begin
                s2_a_reg    <= s1_a_reg;
                s2_prod_reg <= PW'($signed({1'b0, s1_t_reg}) * s1_diff_reg);
            end
        end
    end

    // The arithmetic shift floors the signed product; the true result always
    // lies between a and b, so the sum is exact modulo the value width.
    assign prod_shift = s2_prod_reg >>> FRAC_BITS;
    assign sum        = {1'b0, s2_a_reg} + {1'b0, prod_shift[VALUE_BITS-1:0]};

    assign rsp.done  = s2_valid_reg;
    assign rsp.value = sum[VALUE_BITS-1:0];

endmodule
